FILE: design/fcdo_pkg.sv
// Shared types, constants and font table for the frame counter digit overlay.
package fcdo_pkg;

  localparam int COL_W      = 12;
  localparam int LW_W       = 13;
  localparam int PIX_W      = 8;
  localparam int DIGIT_W    = 4;
  localparam int GLYPH_W    = 4;
  localparam int GLYPH_H    = 5;
  localparam int CELL_W     = GLYPH_W + 1;
  localparam int ROW_IDX_W  = 3;
  localparam int GX_W       = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [PIX_W-1:0]   PIX_ON    = 8'hFF;
  localparam logic [PIX_W-1:0]   PIX_OFF   = 8'h00;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_COL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_ROW = 2'd2;

  localparam logic [LW_W-1:0]  LINE_WIDTH_RST = 13'd320;
  localparam logic [COL_W-1:0] ORIGIN_COL_RST = 12'd10;
  localparam logic [COL_W-1:0] ORIGIN_ROW_RST = 12'd10;

  typedef struct packed {
    logic [LW_W-1:0]  line_width;
    logic [COL_W-1:0] origin_col;
    logic [COL_W-1:0] origin_row;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] row;
  } pos_t;

  // Bit 3 of each row is the leftmost glyph column.
  localparam logic [GLYPH_H-1:0][GLYPH_W-1:0] FONT [10] = '{
    '{4'h6, 4'h9, 4'h9, 4'h9, 4'h6},
    '{4'h2, 4'h6, 4'h2, 4'h2, 4'h2},
    '{4'h6, 4'h9, 4'h2, 4'h4, 4'hF},
    '{4'h6, 4'h9, 4'h2, 4'h9, 4'h6},
    '{4'h8, 4'h9, 4'hF, 4'h1, 4'h1},
    '{4'hF, 4'h8, 4'h6, 4'h1, 4'hE},
    '{4'h7, 4'h8, 4'hE, 4'h9, 4'h6},
    '{4'hF, 4'h1, 4'h2, 4'h4, 4'h8},
    '{4'h6, 4'h9, 4'h6, 4'h9, 4'h6},
    '{4'h6, 4'h9, 4'h7, 4'h1, 4'hE}
  };

  function automatic logic [GLYPH_W-1:0] font_row(input logic [DIGIT_W-1:0] digit,
                                                  input logic [ROW_IDX_W-1:0] row);
    logic [DIGIT_W-1:0] d;
    logic [GLYPH_H-1:0][GLYPH_W-1:0] glyph;
    d = (digit > DIGIT_MAX) ? DIGIT_MAX : digit;
    glyph = FONT[d];
    // Packed array literal puts the first (top) row at the highest index.
    return glyph[3'(GLYPH_H - 1) - row];
  endfunction

endpackage

FILE: design/fcdo_raster_pos.sv
// Column and row counters tracking the raster position of the next pixel.
module fcdo_raster_pos (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic                        frame_end,
  input  logic [fcdo_pkg::LW_W-1:0]   line_width,
  output fcdo_pkg::pos_t              pos
);

  logic [fcdo_pkg::LW_W-1:0] col_inc;
  logic                      line_end;

  assign col_inc  = {1'b0, pos.col} + fcdo_pkg::LW_W'(1);
  assign line_end = (col_inc >= line_width) || (&pos.col);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (step) begin
      if (frame_end) begin
        pos <= '0;
      end else if (line_end) begin
        pos.col <= '0;
        pos.row <= pos.row + fcdo_pkg::COL_W'(1);
      end else begin
        pos.col <= col_inc[fcdo_pkg::COL_W-1:0];
      end
    end
  end

endmodule

FILE: design/fcdo_bcd_counter.sv
// Decimal frame counter, one BCD digit per position, wraps past all nines.
module fcdo_bcd_counter #(
  parameter int NUM_DIGITS = 9
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        inc,
  output logic [NUM_DIGITS-1:0][fcdo_pkg::DIGIT_W-1:0] digits
);

  logic [NUM_DIGITS-1:0][fcdo_pkg::DIGIT_W-1:0] digits_next;

  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      digits_next[i] = digits[i];
      if (carry) begin
        if (digits[i] >= fcdo_pkg::DIGIT_MAX) begin
          digits_next[i] = '0;
        end else begin
          digits_next[i] = digits[i] + fcdo_pkg::DIGIT_W'(1);
          carry = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digits <= '0;
    end else if (inc) begin
      digits <= digits_next;
    end
  end

endmodule

FILE: design/fcdo_glyph_render.sv
// Decides whether the current pixel lies in a glyph and picks the font pixel.
module fcdo_glyph_render #(
  parameter int NUM_DIGITS = 9
) (
  input  fcdo_pkg::pos_t                               pos,
  input  fcdo_pkg::cfg_t                               cfg,
  input  logic [NUM_DIGITS-1:0][fcdo_pkg::DIGIT_W-1:0] digits,
  input  logic [fcdo_pkg::PIX_W-1:0]                   pixel,
  output logic [fcdo_pkg::PIX_W-1:0]                   pixel_mix
);

  localparam int SPAN       = NUM_DIGITS * fcdo_pkg::CELL_W;
  localparam int DC_W       = $clog2(SPAN);
  localparam int CELL_IDX_W = $clog2(NUM_DIGITS + 1);

  logic [fcdo_pkg::COL_W-1:0]   dr;
  logic [fcdo_pkg::COL_W-1:0]   dc;
  logic [DC_W-1:0]              dc_s;
  logic [CELL_IDX_W-1:0]        cell_idx;
  logic [fcdo_pkg::GX_W-1:0]    cx;
  logic [fcdo_pkg::DIGIT_W-1:0] digit;
  logic [fcdo_pkg::GLYPH_W-1:0] bits;
  logic                         in_box;
  logic                         hit;

  assign dr     = pos.row - cfg.origin_row;
  assign dc     = pos.col - cfg.origin_col;
  assign in_box = (pos.row >= cfg.origin_row) && (pos.col >= cfg.origin_col) &&
                  (dr < fcdo_pkg::COL_W'(fcdo_pkg::GLYPH_H)) &&
                  (dc < fcdo_pkg::COL_W'(SPAN));
  assign dc_s   = dc[DC_W-1:0];

  // Cell index and offset within the cell by comparing against cell starts.
  always_comb begin
    cell_idx = '0;
    cx       = fcdo_pkg::GX_W'(dc_s);
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (dc_s >= DC_W'(i * fcdo_pkg::CELL_W)) begin
        cell_idx = CELL_IDX_W'(i);
        cx       = fcdo_pkg::GX_W'(dc_s - DC_W'(i * fcdo_pkg::CELL_W));
      end
    end
  end

  assign hit    = in_box && (cx < fcdo_pkg::GX_W'(fcdo_pkg::GLYPH_W));

  // Leftmost cell shows the most significant digit.
  always_comb begin
    digit = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (cell_idx == CELL_IDX_W'(NUM_DIGITS - 1 - i)) begin
        digit = digits[i];
      end
    end
  end

  assign bits = fcdo_pkg::font_row(digit, dr[fcdo_pkg::ROW_IDX_W-1:0]);

  always_comb begin
    if (!hit) begin
      pixel_mix = pixel;
    end else if (bits[2'(fcdo_pkg::GX_W'(fcdo_pkg::GLYPH_W - 1) - cx)]) begin
      pixel_mix = fcdo_pkg::PIX_ON;
    end else begin
      pixel_mix = fcdo_pkg::PIX_OFF;
    end
  end

endmodule

FILE: design/frame_counter_digit_overlay.sv
// Top level of the frame counter digit overlay.
//
// Stamps the frame number as NUM_DIGITS decimal digits (4x5 font, 5-pixel
// cells, most significant digit leftmost) into an 8-bit raster stream.
// Input channel: in_valid / in_stall with pixel_in and end_of_frame; a
// request is taken when in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall with pixel_out and frame_last.
// A request's result is registered into the output register on the
// following clock edge. While the receiver does not stall, one pixel per
// clock is sustained; the output register is the only storage between the
// two sides. When the receiver stalls, the output register holds and
// in_stall rises, so no request is taken until the held result is delivered.
// Config: cfg_write, cfg_index, cfg_data; index 0 line_width, 1 origin_col,
// 2 origin_row; other indexes are ignored. Write only while idle.
// Reset (rst, synchronous) empties the output register, clears position
// and frame count, and loads line_width 320, origin_col 10, origin_row 10.
module frame_counter_digit_overlay #(
  parameter int NUM_DIGITS = 9
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      pixel_in,
  input  logic                            end_of_frame,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      pixel_out,
  output logic                            frame_last,
  input  logic                            cfg_write,
  input  logic [fcdo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fcdo_pkg::CFG_DATA_W-1:0] cfg_data
);

  fcdo_pkg::cfg_t                               cfg;
  fcdo_pkg::pos_t                               pos;
  logic [NUM_DIGITS-1:0][fcdo_pkg::DIGIT_W-1:0] digits;
  logic [fcdo_pkg::PIX_W-1:0]                   pixel_mix;
  logic                                         take;

  assign in_stall = out_valid && out_stall;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_width <= fcdo_pkg::LINE_WIDTH_RST;
      cfg.origin_col <= fcdo_pkg::ORIGIN_COL_RST;
      cfg.origin_row <= fcdo_pkg::ORIGIN_ROW_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        fcdo_pkg::REG_LINE_WIDTH: cfg.line_width <= cfg_data;
        fcdo_pkg::REG_ORIGIN_COL: cfg.origin_col <= cfg_data[fcdo_pkg::COL_W-1:0];
        fcdo_pkg::REG_ORIGIN_ROW: cfg.origin_row <= cfg_data[fcdo_pkg::COL_W-1:0];
        default: ;
      endcase
    end
  end

  fcdo_raster_pos u_pos (
    .clk        (clk),
    .rst        (rst),
    .step       (take),
    .frame_end  (end_of_frame),
    .line_width (cfg.line_width),
    .pos        (pos)
  );

  fcdo_bcd_counter #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_count (
    .clk    (clk),
    .rst    (rst),
    .inc    (take && end_of_frame),
    .digits (digits)
  );

  fcdo_glyph_render #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_render (
    .pos       (pos),
    .cfg       (cfg),
    .digits    (digits),
    .pixel     (pixel_in),
    .pixel_mix (pixel_mix)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pixel_out  <= pixel_mix;
      frame_last <= end_of_frame;
    end
  end

endmodule

FILE: tb/sv/tb_frame_counter_digit_overlay.sv
// Self-checking testbench for the frame counter digit overlay.
`timescale 1ns / 1ps

module tb_frame_counter_digit_overlay;

  localparam int DIGITS      = 9;
  localparam int GLYPH_COLS  = 4;
  localparam int GLYPH_ROWS  = 5;
  localparam int CELL_PITCH  = GLYPH_COLS + 1;
  localparam int ITEM_TARGET = 1650;
  localparam int QUIET_TAIL  = 200;
  localparam int CYCLE_LIMIT = 300000;

  localparam logic [fcdo_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Row 0 is the top glyph row; bit 3 is the leftmost column.
  localparam bit [3:0] DIGIT_FONT [10][5] = '{
    '{4'h6, 4'h9, 4'h9, 4'h9, 4'h6},
    '{4'h2, 4'h6, 4'h2, 4'h2, 4'h2},
    '{4'h6, 4'h9, 4'h2, 4'h4, 4'hF},
    '{4'h6, 4'h9, 4'h2, 4'h9, 4'h6},
    '{4'h8, 4'h9, 4'hF, 4'h1, 4'h1},
    '{4'hF, 4'h8, 4'h6, 4'h1, 4'hE},
    '{4'h7, 4'h8, 4'hE, 4'h9, 4'h6},
    '{4'hF, 4'h1, 4'h2, 4'h4, 4'h8},
    '{4'h6, 4'h9, 4'h6, 4'h9, 4'h6},
    '{4'h6, 4'h9, 4'h7, 4'h1, 4'hE}
  };

  typedef struct packed {
    logic [fcdo_pkg::PIX_W-1:0] pixel;
    logic                       last;
  } stamped_t;

  class stamped_pixel_tracker;
    logic [fcdo_pkg::LW_W-1:0]    width_reg;
    logic [fcdo_pkg::COL_W-1:0]   org_col;
    logic [fcdo_pkg::COL_W-1:0]   org_row;
    logic [fcdo_pkg::COL_W-1:0]   col_pos;
    logic [fcdo_pkg::COL_W-1:0]   row_pos;
    logic [fcdo_pkg::DIGIT_W-1:0] bcd [DIGITS];
    stamped_t stamped_q [$];
    int errors;
    int checked;
    int frames;

    function new();
      width_reg = fcdo_pkg::LINE_WIDTH_RST;
      org_col   = fcdo_pkg::ORIGIN_COL_RST;
      org_row   = fcdo_pkg::ORIGIN_ROW_RST;
      col_pos   = '0;
      row_pos   = '0;
      foreach (bcd[i]) bcd[i] = '0;
      errors  = 0;
      checked = 0;
      frames  = 0;
    endfunction

    function void write_reg(logic [fcdo_pkg::CFG_IDX_W-1:0] idx,
                            logic [fcdo_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        fcdo_pkg::REG_LINE_WIDTH: width_reg = data;
        fcdo_pkg::REG_ORIGIN_COL: org_col = data[fcdo_pkg::COL_W-1:0];
        fcdo_pkg::REG_ORIGIN_ROW: org_row = data[fcdo_pkg::COL_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_pixel(logic [fcdo_pkg::PIX_W-1:0] pix, logic eof);
      int dr, dc, cell_no, cx, d;
      stamped_t item;
      item.pixel = pix;
      item.last  = eof;
      if (row_pos >= org_row && col_pos >= org_col) begin
        dr      = int'(row_pos) - int'(org_row);
        dc      = int'(col_pos) - int'(org_col);
        cell_no = dc / CELL_PITCH;
        cx      = dc % CELL_PITCH;
        if (dr < GLYPH_ROWS && cell_no < DIGITS && cx < GLYPH_COLS) begin
          d = int'(bcd[DIGITS-1-cell_no]);
          if (d > 9) d = 9;
          item.pixel = DIGIT_FONT[d][dr][GLYPH_COLS-1-cx] ? fcdo_pkg::PIX_ON
                                                          : fcdo_pkg::PIX_OFF;
        end
      end
      stamped_q.push_back(item);
      if (eof) begin
        col_pos = '0;
        row_pos = '0;
        frames++;
        for (int i = 0; i < DIGITS; i++) begin
          if (bcd[i] >= 9) begin
            bcd[i] = '0;
          end else begin
            bcd[i] = bcd[i] + fcdo_pkg::DIGIT_W'(1);
            break;
          end
        end
      end else if (int'(col_pos) + 1 >= int'(width_reg) || col_pos == 12'hFFF) begin
        col_pos = '0;
        row_pos = row_pos + fcdo_pkg::COL_W'(1);
      end else begin
        col_pos = col_pos + fcdo_pkg::COL_W'(1);
      end
    endfunction

    function void match_pixel(logic [fcdo_pkg::PIX_W-1:0] pix, logic last);
      stamped_t want;
      if (stamped_q.size() == 0) begin
        $error("result with no request pending: pixel_out %0d frame_last %0d", pix, last);
        errors++;
        return;
      end
      want = stamped_q.pop_front();
      checked++;
      if (pix !== want.pixel) begin
        $error("pixel_out mismatch: expected %0d, actual %0d", want.pixel, pix);
        errors++;
      end
      if (last !== want.last) begin
        $error("frame_last mismatch: expected %0d, actual %0d", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [fcdo_pkg::PIX_W-1:0] pixel_in = '0;
  logic end_of_frame = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [fcdo_pkg::PIX_W-1:0] pixel_out;
  logic frame_last;
  logic cfg_write = 1'b0;
  logic [fcdo_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fcdo_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  stamped_pixel_tracker tracker;
  int cycle_count = 0;
  int random_sent = 0;
  int settings_made = 0;
  int stall_left = 0;
  bit gap_enable = 1'b0;
  bit stall_enable = 1'b0;

  frame_counter_digit_overlay #(.NUM_DIGITS(DIGITS)) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel_in    (pixel_in),
    .end_of_frame(end_of_frame),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_out   (pixel_out),
    .frame_last  (frame_last),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // Random receiver stall bursts while stalls are enabled.
  always @(posedge clk) begin
    if (rst || !stall_enable) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.match_pixel(pixel_out, frame_last);
  end

  task automatic send_pixel(input logic [fcdo_pkg::PIX_W-1:0] pix, input logic eof);
    if (gap_enable && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    pixel_in     <= pix;
    end_of_frame <= eof;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_pixel(pix, eof);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.stamped_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [fcdo_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fcdo_pkg::CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [fcdo_pkg::CFG_DATA_W-1:0] lw,
                           input logic [fcdo_pkg::CFG_DATA_W-1:0] oc,
                           input logic [fcdo_pkg::CFG_DATA_W-1:0] orow);
    drain();
    write_reg(fcdo_pkg::REG_LINE_WIDTH, lw);
    write_reg(fcdo_pkg::REG_ORIGIN_COL, oc);
    write_reg(fcdo_pkg::REG_ORIGIN_ROW, orow);
    settings_made++;
  endtask

  // Mostly whole frames that sweep the digit area, plus short broken frames
  // and runs of end-of-frame pixels that push the counter along.
  task automatic run_phase(input int lw, input int oc, input int orow, input int target);
    int sent, len, eff, kind, rows;
    bit paused;
    configure(fcdo_pkg::CFG_DATA_W'(lw), fcdo_pkg::CFG_DATA_W'(oc),
              fcdo_pkg::CFG_DATA_W'(orow));
    gap_enable   = ($urandom_range(0, 3) != 0);
    stall_enable = ($urandom_range(0, 3) != 0);
    sent   = 0;
    paused = 1'b0;
    eff    = (lw == 0) ? 1 : lw;
    rows   = orow & 12'hFFF;
    while (sent < target) begin
      if (random_sent + sent >= ITEM_TARGET - QUIET_TAIL) begin
        gap_enable   = 1'b0;
        stall_enable = 1'b0;
      end
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        len = eff * (rows + GLYPH_ROWS) + $urandom_range(0, eff);
        if (len > 400) len = $urandom_range(20, 60);
        for (int k = 0; k < len; k++) begin
          send_pixel(fcdo_pkg::PIX_W'($urandom_range(0, 255)), k == len - 1);
        end
        sent += len;
        if (!paused) begin
          drain();
          paused = 1'b1;
        end
      end else if (kind < 9) begin
        len = $urandom_range(1, 3);
        for (int k = 0; k < len; k++) begin
          send_pixel(fcdo_pkg::PIX_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        sent += len;
      end else begin
        len = $urandom_range(5, 20);
        for (int k = 0; k < len; k++) send_pixel(fcdo_pkg::PIX_W'($urandom_range(0, 255)), 1'b1);
        sent += len;
      end
    end
    random_sent += sent;
  endtask

  initial begin
    tracker = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset settings: raster far from the digits
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'hA5, 1'b0);

    // out-of-range index ignored; zero line width keeps the column at 0
    drain();
    write_reg(REG_UNUSED, 13'h1FFF);
    configure(13'd0, 13'd0, 13'd0);
    for (int k = 0; k < 8; k++) send_pixel((k % 2) ? 8'hFF : 8'h00, 1'b0);
    send_pixel(8'h3C, 1'b1);

    // narrow line clips the first cell's last column
    configure(13'd7, 13'd4, 13'd0);
    for (int k = 0; k < 12; k++) send_pixel(fcdo_pkg::PIX_W'($urandom_range(0, 255)), k == 11);

    run_phase(4096, 13'h1FFF, 4095, 40);
    run_phase(1, 0, 0, 60);
    run_phase(45, 0, 0, 300);
    run_phase(0, 0, 3, 60);
    while (random_sent < ITEM_TARGET) begin
      run_phase(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 60),
                $urandom_range(0, 15), $urandom_range(0, 3), $urandom_range(150, 260));
    end

    drain();
    repeat (4) @(posedge clk);
    if (tracker.stamped_q.size() != 0) begin
      $error("%0d requests never produced a result", tracker.stamped_q.size());
      tracker.errors++;
    end
    $display("Checked %0d pixels over %0d frames under %0d register settings.",
             tracker.checked, tracker.frames, settings_made);
    $display("Line widths 0 to 4096, origins 0 to 4095, with sender gaps and receiver stalls.");
    if (tracker.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: frame_counter_digit_overlay.f
design/fcdo_pkg.sv
design/fcdo_raster_pos.sv
design/fcdo_bcd_counter.sv
design/fcdo_glyph_render.sv
design/frame_counter_digit_overlay.sv
tb/sv/tb_frame_counter_digit_overlay.sv
